// ===== rtl/tcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsp_pkg
// Shared types and constants of the text command stream parser: result kinds,
// controller states, token phases, characters and the control/status bundles.
// ----------------------------------------------------------------------------
package tcsp_pkg;

	// Input opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_DISC = 1'b1;

	// Characters the parser reacts to
	localparam logic [7:0] CH_NAME   = 8'h6E; // n
	localparam logic [7:0] CH_JOIN   = 8'h6A; // j
	localparam logic [7:0] CH_QUIT   = 8'h71; // q
	localparam logic [7:0] CH_MOVE   = 8'h6D; // m
	localparam logic [7:0] CH_ATTACK = 8'h61; // a
	localparam logic [7:0] CH_MINE   = 8'h64; // d
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Magnitude limits of an integer field
	localparam logic [31:0] ACC_CAP     = 32'h8000_0001;
	localparam logic [31:0] ACC_NEG_MAX = 32'h8000_0000;
	localparam logic [31:0] ACC_POS_MAX = 32'h7FFF_FFFF;

	// Index of the final integer field of a move message
	localparam logic [1:0] MOVE_LAST_FIELD = 2'd3;
	localparam logic [1:0] FIRST_FIELD     = 2'd0;

	typedef enum logic [2:0] {
		KIND_UNKNOWN = 3'd0,
		KIND_NAME    = 3'd1,
		KIND_JOIN    = 3'd2,
		KIND_QUIT    = 3'd3,
		KIND_MOVE    = 3'd4,
		KIND_ATTACK  = 3'd5,
		KIND_MINE    = 3'd6,
		KIND_DISC    = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0, // awaiting a type byte
		ST_NAME  = 2'd1, // collecting name characters
		ST_FIELD = 2'd2, // decoding integer fields
		ST_EMIT  = 2'd3  // streaming the name out
	} state_t;

	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2,
		PH_JUNK  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		SRC_NONE = 2'd0, // all payload fields zero
		SRC_PAIR = 2'd1, // attack / mine
		SRC_MOVE = 2'd2,
		SRC_NAME = 2'd3
	} src_t;

	// Controller to datapath
	typedef struct packed {
		logic  tok_clear;
		logic  tok_step;
		logic  fld_clear;
		logic  fld_capture;
		logic  name_clear;
		logic  name_push;
		logic  emit_start;
		logic  emit_next;
		logic  out_load;
		kind_t out_kind;
		src_t  out_src;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic       byte_ws;
		logic       byte_nl;
		logic       byte_sp;
		logic       field_bad;
		logic [1:0] field_idx;
		logic       emit_last;
	} sts_t;

endpackage

// ===== rtl/tcsp_dpath.sv =====
// ----------------------------------------------------------------------------
// tcsp_dpath
// Datapath: byte classification, integer token decoder, captured fields,
// name buffer with registered read, and the result payload register.
// ----------------------------------------------------------------------------
module tcsp_dpath #(
	parameter int NAME_MAX = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tcsp_pkg::cmd_t                       cmd,
	input  logic [7:0]                           rx_byte,
	output tcsp_pkg::sts_t                       sts,
	output logic [2:0]                           kind,
	output logic signed [31:0]                   field_a,
	output logic signed [31:0]                   field_b,
	output logic signed [31:0]                   field_c,
	output logic signed [31:0]                   field_d,
	output logic [7:0]                           name_char,
	output logic [$clog2(NAME_MAX + 1) - 1:0]    name_length,
	output logic                                 name_overflow,
	output logic                                 last
);

	localparam int AW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;
	localparam int LW = $clog2(NAME_MAX + 1);
	localparam logic [LW-1:0] NAME_CAP = LW'(NAME_MAX);

	// Token state
	tcsp_pkg::phase_t phase_q, phase_d;
	logic [31:0]      acc_q, acc_d;
	logic             neg_q, neg_d;
	logic             rerr_q, rerr_d;
	logic [1:0]       fidx_q;

	// Earlier integers of the message
	logic [31:0]      cap_q [3];

	// Name buffer
	logic [7:0]       name_mem [NAME_MAX];
	logic [LW-1:0]    name_count_q;
	logic             name_over_q;
	logic [AW-1:0]    emit_idx_q, emit_idx_d;
	logic [7:0]       rd_data_q;

	// Byte classification
	logic             is_digit;
	logic [3:0]       digit;
	logic [35:0]      acc_x10;
	logic [31:0]      value;

	assign is_digit = (rx_byte >= tcsp_pkg::CH_ZERO) && (rx_byte <= tcsp_pkg::CH_NINE);
	assign digit    = 4'(rx_byte - tcsp_pkg::CH_ZERO);

	assign sts.byte_ws   = (rx_byte == tcsp_pkg::CH_SPACE) ||
	                       ((rx_byte >= tcsp_pkg::CH_TAB) && (rx_byte <= tcsp_pkg::CH_CR));
	assign sts.byte_nl   = (rx_byte == tcsp_pkg::CH_NL);
	assign sts.byte_sp   = (rx_byte == tcsp_pkg::CH_SPACE);
	assign sts.field_idx = fidx_q;
	assign sts.field_bad = rerr_q || (phase_q == tcsp_pkg::PH_LEAD) ||
	                       (phase_q == tcsp_pkg::PH_SIGN) ||
	                       (!neg_q && (acc_q > tcsp_pkg::ACC_POS_MAX)) ||
	                       (neg_q && (acc_q > tcsp_pkg::ACC_NEG_MAX));
	assign sts.emit_last = (name_count_q == '0) ||
	                       ((LW'(emit_idx_q) + LW'(1)) == name_count_q);

	// Signed value of the finished token
	assign value = neg_q ? (~acc_q + 32'd1) : acc_q;

	// acc * 10 + digit, wide enough to see the overflow
	assign acc_x10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {32'd0, digit};

	// Token decoder next state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		rerr_d  = rerr_q;
		if (cmd.tok_clear) begin
			phase_d = tcsp_pkg::PH_LEAD;
			acc_d   = '0;
			neg_d   = 1'b0;
			rerr_d  = 1'b0;
		end else if (cmd.tok_step) begin
			if (is_digit && (phase_q != tcsp_pkg::PH_JUNK)) begin
				phase_d = tcsp_pkg::PH_DIGIT;
				if (acc_x10 > {4'd0, tcsp_pkg::ACC_NEG_MAX}) begin
					acc_d  = tcsp_pkg::ACC_CAP;
					rerr_d = 1'b1;
				end else begin
					acc_d = acc_x10[31:0];
				end
			end else if (phase_q == tcsp_pkg::PH_LEAD) begin
				if (sts.byte_ws) begin
					phase_d = tcsp_pkg::PH_LEAD;
				end else if ((rx_byte == tcsp_pkg::CH_PLUS) ||
				             (rx_byte == tcsp_pkg::CH_MINUS)) begin
					neg_d   = (rx_byte == tcsp_pkg::CH_MINUS);
					phase_d = tcsp_pkg::PH_SIGN;
				end else begin
					rerr_d  = 1'b1;
					phase_d = tcsp_pkg::PH_JUNK;
				end
			end else if (phase_q == tcsp_pkg::PH_SIGN) begin
				rerr_d  = 1'b1;
				phase_d = tcsp_pkg::PH_JUNK;
			end else begin
				phase_d = tcsp_pkg::PH_JUNK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tcsp_pkg::PH_LEAD;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			rerr_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			rerr_q  <= rerr_d;
		end
	end

	// Field index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fidx_q <= '0;
		end else if (cmd.fld_clear) begin
			fidx_q <= '0;
		end else if (cmd.fld_capture) begin
			fidx_q <= fidx_q + 2'd1;
		end
	end

	// Captured fields, written at the index of the finished field
	always_ff @(posedge clk) begin
		if (cmd.fld_capture) begin
			cap_q[fidx_q] <= value;
		end
	end

	// Name fill count and overflow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_count_q <= '0;
			name_over_q  <= 1'b0;
		end else if (cmd.name_clear) begin
			name_count_q <= '0;
			name_over_q  <= 1'b0;
		end else if (cmd.name_push) begin
			if (name_count_q < NAME_CAP) begin
				name_count_q <= name_count_q + LW'(1);
			end else begin
				name_over_q <= 1'b1;
			end
		end
	end

	// Name memory write port
	always_ff @(posedge clk) begin
		if (cmd.name_push && (name_count_q < NAME_CAP)) begin
			name_mem[name_count_q[AW-1:0]] <= rx_byte;
		end
	end

	// Read index: read data always holds the entry at the current index
	always_comb begin
		emit_idx_d = emit_idx_q;
		if (cmd.emit_start) begin
			emit_idx_d = '0;
		end else if (cmd.emit_next) begin
			emit_idx_d = emit_idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_idx_q <= '0;
		end else begin
			emit_idx_q <= emit_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= name_mem[emit_idx_d];
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind          <= cmd.out_kind;
			field_a       <= '0;
			field_b       <= '0;
			field_c       <= '0;
			field_d       <= '0;
			name_char     <= '0;
			name_length   <= '0;
			name_overflow <= 1'b0;
			last          <= 1'b1;
			case (cmd.out_src)
				tcsp_pkg::SRC_PAIR: begin
					field_a <= cap_q[0];
					field_b <= value;
				end
				tcsp_pkg::SRC_MOVE: begin
					field_a <= cap_q[0];
					field_b <= cap_q[1];
					field_c <= cap_q[2];
					field_d <= value;
				end
				tcsp_pkg::SRC_NAME: begin
					name_char     <= (name_count_q == '0) ? 8'd0 : rd_data_q;
					name_length   <= name_count_q;
					name_overflow <= name_over_q;
					last          <= sts.emit_last;
				end
				default: begin
					last <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== rtl/tcsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcsp_ctrl
// Controller: message state machine, input and output handshakes, and the
// command bundle that drives the datapath.
// ----------------------------------------------------------------------------
module tcsp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           opcode,
	input  logic [7:0]     rx_byte,
	output logic           out_valid,
	input  logic           out_ready,
	input  tcsp_pkg::sts_t sts,
	output tcsp_pkg::cmd_t cmd
);

	tcsp_pkg::state_t state_q, state_d;
	tcsp_pkg::kind_t  msg_q, msg_d;
	logic             out_valid_q, out_valid_d;
	logic             out_free;
	logic             accept;
	logic             field_last;
	logic             delim_hit;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q != tcsp_pkg::ST_EMIT) && out_free;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Final field of the message ends at newline, earlier ones at space
	assign field_last = (msg_q == tcsp_pkg::KIND_MOVE) ?
	                    (sts.field_idx == tcsp_pkg::MOVE_LAST_FIELD) :
	                    (sts.field_idx != tcsp_pkg::FIRST_FIELD);
	assign delim_hit  = field_last ? sts.byte_nl : sts.byte_sp;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcsp_pkg::ST_IDLE;
			msg_q       <= tcsp_pkg::KIND_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			msg_q       <= msg_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d         = state_q;
		msg_d           = msg_q;
		cmd.tok_clear   = 1'b0;
		cmd.tok_step    = 1'b0;
		cmd.fld_clear   = 1'b0;
		cmd.fld_capture = 1'b0;
		cmd.name_clear  = 1'b0;
		cmd.name_push   = 1'b0;
		cmd.emit_start  = 1'b0;
		cmd.emit_next   = 1'b0;
		cmd.out_load    = 1'b0;
		cmd.out_kind    = tcsp_pkg::KIND_UNKNOWN;
		cmd.out_src     = tcsp_pkg::SRC_NONE;

		if (accept && (opcode == tcsp_pkg::OP_DISC)) begin
			// disconnect: report it, parser state untouched
			cmd.out_load = 1'b1;
			cmd.out_kind = tcsp_pkg::KIND_DISC;
		end else begin
			unique case (state_q)
				tcsp_pkg::ST_IDLE: begin
					if (accept && !sts.byte_ws) begin
						cmd.tok_clear  = 1'b1;
						cmd.fld_clear  = 1'b1;
						cmd.name_clear = 1'b1;
						unique case (rx_byte)
							tcsp_pkg::CH_NAME: begin
								state_d = tcsp_pkg::ST_NAME;
							end
							tcsp_pkg::CH_MOVE: begin
								state_d = tcsp_pkg::ST_FIELD;
								msg_d   = tcsp_pkg::KIND_MOVE;
							end
							tcsp_pkg::CH_ATTACK: begin
								state_d = tcsp_pkg::ST_FIELD;
								msg_d   = tcsp_pkg::KIND_ATTACK;
							end
							tcsp_pkg::CH_MINE: begin
								state_d = tcsp_pkg::ST_FIELD;
								msg_d   = tcsp_pkg::KIND_MINE;
							end
							tcsp_pkg::CH_JOIN: begin
								cmd.out_load = 1'b1;
								cmd.out_kind = tcsp_pkg::KIND_JOIN;
							end
							tcsp_pkg::CH_QUIT: begin
								cmd.out_load = 1'b1;
								cmd.out_kind = tcsp_pkg::KIND_QUIT;
							end
							default: begin
								cmd.out_load = 1'b1;
								cmd.out_kind = tcsp_pkg::KIND_UNKNOWN;
							end
						endcase
					end
				end
				tcsp_pkg::ST_NAME: begin
					if (accept) begin
						if (sts.byte_nl) begin
							state_d        = tcsp_pkg::ST_EMIT;
							cmd.emit_start = 1'b1;
						end else begin
							cmd.name_push = 1'b1;
						end
					end
				end
				tcsp_pkg::ST_FIELD: begin
					if (accept) begin
						if (!delim_hit) begin
							cmd.tok_step = 1'b1;
						end else if (sts.field_bad) begin
							// bad field drops the whole message
							state_d = tcsp_pkg::ST_IDLE;
						end else if (!field_last) begin
							cmd.fld_capture = 1'b1;
							cmd.tok_clear   = 1'b1;
						end else begin
							state_d      = tcsp_pkg::ST_IDLE;
							cmd.out_load = 1'b1;
							cmd.out_kind = msg_q;
							cmd.out_src  = (msg_q == tcsp_pkg::KIND_MOVE) ?
							               tcsp_pkg::SRC_MOVE : tcsp_pkg::SRC_PAIR;
						end
					end
				end
				tcsp_pkg::ST_EMIT: begin
					// one name character per transfer
					if (out_free) begin
						cmd.out_load  = 1'b1;
						cmd.out_kind  = tcsp_pkg::KIND_NAME;
						cmd.out_src   = tcsp_pkg::SRC_NAME;
						cmd.emit_next = 1'b1;
						if (sts.emit_last) begin
							state_d = tcsp_pkg::ST_IDLE;
						end
					end
				end
				default: begin
					state_d = tcsp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output valid register
	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

`ifndef SYNTHESIS
	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a result is pending");

	// The last name character returns the controller to idle
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcsp_pkg::ST_EMIT && cmd.out_load && sts.emit_last)
		|=> (state_q == tcsp_pkg::ST_IDLE))
		else $error("name run did not end at its last character");

	// A newline in a name always starts a name run
	a_emit_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcsp_pkg::ST_NAME && accept && opcode == tcsp_pkg::OP_BYTE
		 && sts.byte_nl) |=> (state_q == tcsp_pkg::ST_EMIT && !in_ready))
		else $error("name delimiter did not start emission");

	// Every loaded result shows up on the output channel
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");
`endif

endmodule

// ===== rtl/text_command_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// text_command_stream_parser_top
// Parses a byte stream of text commands into typed result items.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one transfer carries either a received
// byte (opcode 0, rx_byte) or a client disconnect event (opcode 1).
// Output channel (out_valid/out_ready): one transfer carries one result item
// (kind, field_a..field_d, name_char, name_length, name_overflow, last).
// Throughput: one input byte per cycle while results are taken. A byte that
// completes a join, quit, unknown, move, attack, mine or disconnect result
// has its result registered and on the output in the cycle after the transfer.
// A newline that ends a name starts a run of max(1, N) name results, one per
// cycle while results are taken, from the name buffer's registered read port;
// each passes through the read data register and then the result register.
// Input is held off for that run (N = kept characters).
// Receiver stall: the output register holds its result and input is refused
// until the result is taken. Reset clears the parser to the awaiting-type
// state with no result pending; the name buffer needs no clearing.
// ----------------------------------------------------------------------------
module text_command_stream_parser_top #(
	parameter int NAME_MAX = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              opcode,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        kind,
	output logic signed [31:0]                field_a,
	output logic signed [31:0]                field_b,
	output logic signed [31:0]                field_c,
	output logic signed [31:0]                field_d,
	output logic [7:0]                        name_char,
	output logic [$clog2(NAME_MAX + 1) - 1:0] name_length,
	output logic                              name_overflow,
	output logic                              last
);

	tcsp_pkg::cmd_t cmd;
	tcsp_pkg::sts_t sts;

	// Message controller
	tcsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Token decoder, buffers and result register
	tcsp_dpath #(
		.NAME_MAX (NAME_MAX)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rx_byte       (rx_byte),
		.sts           (sts),
		.kind          (kind),
		.field_a       (field_a),
		.field_b       (field_b),
		.field_c       (field_c),
		.field_d       (field_d),
		.name_char     (name_char),
		.name_length   (name_length),
		.name_overflow (name_overflow),
		.last          (last)
	);

endmodule
